// ===== hw/rtl/tgad_pkg.sv =====
// Package for the TGA stream decoder: parse phases, result codes,
// header signatures and the result word passed from the parser to the top.
// No dependencies.
package tgad_pkg;

  typedef enum logic [2:0] {
    PH_SIG,
    PH_INFO,
    PH_HDR,
    PH_PIX,
    PH_DONE
  } phase_e;

  typedef enum logic [1:0] {
    KIND_PIXEL,
    KIND_INFO,
    KIND_ERROR
  } kind_e;

  typedef enum logic [1:0] {
    ERR_NONE,
    ERR_SIGNATURE,
    ERR_INFO,
    ERR_PIXELS
  } err_e;

  localparam int unsigned SigLen   = 12;
  localparam logic [3:0]  SIG_LAST = 4'(SigLen - 1);
  localparam logic [2:0]  INFO_KEEP = 3'd5;  // bytes of image spec that are kept
  localparam logic [2:0]  INFO_LAST = 3'd5;  // descriptor byte, ignored

  localparam logic [7:0] SIG_RAW [SigLen] = '{
    8'd0, 8'd0, 8'd2, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0
  };
  localparam logic [7:0] SIG_RLE [SigLen] = '{
    8'd0, 8'd0, 8'd10, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0
  };

  localparam logic [7:0] RUN_BIAS = 8'd127;
  localparam logic [7:0] BPP_24   = 8'd24;
  localparam logic [7:0] BPP_32   = 8'd32;

  typedef struct packed {
    kind_e       result_kind;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [7:0]  alpha;
    logic [7:0]  run_length;
    logic [15:0] image_width;
    logic [15:0] image_height;
    logic [7:0]  bits_per_pixel;
    err_e        error_code;
    logic        last;
  } result_t;

endpackage

// ===== hw/rtl/tgad_if.sv =====
// Stream channel interfaces of the TGA decoder: byte input and result output.
// Valid/ready handshake; a word moves when both are high at a clock edge.
interface tgad_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       start_of_file;

  modport source (output valid, output data_byte, output start_of_file, input ready);
  modport sink   (input valid, input data_byte, input start_of_file, output ready);
endinterface

interface tgad_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  result_kind;
  logic [7:0]  red;
  logic [7:0]  green;
  logic [7:0]  blue;
  logic [7:0]  alpha;
  logic [7:0]  run_length;
  logic [15:0] image_width;
  logic [15:0] image_height;
  logic [7:0]  bits_per_pixel;
  logic [1:0]  error_code;
  logic        last;

  modport source (
    output valid, output result_kind, output red, output green, output blue,
    output alpha, output run_length, output image_width, output image_height,
    output bits_per_pixel, output error_code, output last, input ready
  );
  modport sink (
    input valid, input result_kind, input red, input green, input blue,
    input alpha, input run_length, input image_width, input image_height,
    input bits_per_pixel, input error_code, input last, output ready
  );
endinterface

// ===== hw/rtl/tgad_parser.sv =====
// TGA byte parser: signature check, image spec, RLE packets and pixel assembly.
// Takes one byte per step and gives at most one result word. Uses tgad_pkg.
module tgad_parser (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              step_i,
  input  logic [7:0]        data_byte_i,
  input  logic              start_of_file_i,
  output logic              res_valid_o,
  output tgad_pkg::result_t res_o
);

  tgad_pkg::phase_e phase_q, phase_d, phase_c;
  logic [3:0]  pos_q, pos_d, pos_c;
  logic        raw_q, raw_d, raw_c;
  logic        rle_q, rle_d, rle_c;
  logic [39:0] hdr_q, hdr_d;
  logic        four_q, four_d, four_c;
  logic [31:0] remain_q, remain_d, remain_c;
  logic        run_q, run_d, run_c;
  logic [7:0]  left_q, left_d, left_c;
  logic [23:0] pix_q, pix_d;
  logic [1:0]  bip_q, bip_d, bip_c;

  logic [3:0]  sig_idx;
  logic        raw_hit, rle_hit;
  logic [15:0] hdr_w, hdr_h;
  logic [7:0]  hdr_bpp;
  logic [31:0] area;
  logic        info_bad;
  logic [1:0]  bip_need;
  logic [7:0]  pix_r, pix_g, pix_b, pix_a;
  logic [31:0] remain_dec, remain_sub;
  logic [7:0]  left_dec;
  logic        run_too_long;

  // start_of_file restarts the parser before the byte is taken
  assign phase_c  = start_of_file_i ? tgad_pkg::PH_SIG : phase_q;
  assign pos_c    = start_of_file_i ? 4'd0  : pos_q;
  assign raw_c    = start_of_file_i ? 1'b1  : raw_q;
  assign rle_c    = start_of_file_i ? 1'b1  : rle_q;
  assign four_c   = start_of_file_i ? 1'b0  : four_q;
  assign remain_c = start_of_file_i ? 32'd0 : remain_q;
  assign run_c    = start_of_file_i ? 1'b0  : run_q;
  assign left_c   = start_of_file_i ? 8'd0  : left_q;
  assign bip_c    = start_of_file_i ? 2'd0  : bip_q;

  assign sig_idx = (pos_c < 4'(tgad_pkg::SigLen)) ? pos_c : tgad_pkg::SIG_LAST;
  assign raw_hit = raw_c && (data_byte_i == tgad_pkg::SIG_RAW[sig_idx]);
  assign rle_hit = rle_c && (data_byte_i == tgad_pkg::SIG_RLE[sig_idx]);

  assign hdr_w   = hdr_q[15:0];
  assign hdr_h   = hdr_q[31:16];
  assign hdr_bpp = hdr_q[39:32];
  assign area    = 32'(hdr_w) * 32'(hdr_h);
  assign info_bad = (hdr_w == 16'd0) || (hdr_h == 16'd0) ||
                    ((hdr_bpp != tgad_pkg::BPP_24) && (hdr_bpp != tgad_pkg::BPP_32));

  assign bip_need = four_c ? 2'd3 : 2'd2;
  assign pix_b = pix_q[7:0];
  assign pix_g = pix_q[15:8];
  assign pix_r = four_c ? pix_q[23:16] : data_byte_i;
  assign pix_a = four_c ? data_byte_i : 8'd0;

  assign remain_dec   = remain_c - 32'd1;
  assign remain_sub   = remain_c - {24'd0, left_c};
  assign left_dec     = left_c - 8'd1;
  assign run_too_long = {24'd0, left_c} > remain_c;

  always_comb begin
    phase_d  = phase_q;
    pos_d    = pos_q;
    raw_d    = raw_q;
    rle_d    = rle_q;
    hdr_d    = hdr_q;
    four_d   = four_q;
    remain_d = remain_q;
    run_d    = run_q;
    left_d   = left_q;
    pix_d    = pix_q;
    bip_d    = bip_q;
    res_valid_o = 1'b0;
    res_o       = '0;

    if (step_i) begin
      phase_d  = phase_c;
      pos_d    = pos_c;
      raw_d    = raw_c;
      rle_d    = rle_c;
      four_d   = four_c;
      remain_d = remain_c;
      run_d    = run_c;
      left_d   = left_c;
      bip_d    = bip_c;

      case (phase_c)
        tgad_pkg::PH_SIG: begin
          raw_d = raw_hit;
          rle_d = rle_hit;
          pos_d = sig_idx + 4'd1;
          if (sig_idx == tgad_pkg::SIG_LAST) begin
            pos_d = 4'd0;
            if (!raw_hit && !rle_hit) begin
              phase_d = tgad_pkg::PH_DONE;
              res_valid_o = 1'b1;
              res_o.result_kind = tgad_pkg::KIND_ERROR;
              res_o.error_code  = tgad_pkg::ERR_SIGNATURE;
              res_o.last        = 1'b1;
            end else begin
              phase_d = tgad_pkg::PH_INFO;
            end
          end
        end

        tgad_pkg::PH_INFO: begin
          case (pos_c[2:0])
            3'd0:    hdr_d[7:0]   = data_byte_i;
            3'd1:    hdr_d[15:8]  = data_byte_i;
            3'd2:    hdr_d[23:16] = data_byte_i;
            3'd3:    hdr_d[31:24] = data_byte_i;
            3'd4:    hdr_d[39:32] = data_byte_i;
            default: hdr_d = hdr_q;
          endcase
          pos_d = pos_c + 4'd1;
          if (pos_c[2:0] == tgad_pkg::INFO_LAST) begin
            pos_d = 4'd0;
            res_valid_o = 1'b1;
            if (info_bad) begin
              phase_d = tgad_pkg::PH_DONE;
              res_o.result_kind = tgad_pkg::KIND_ERROR;
              res_o.error_code  = tgad_pkg::ERR_INFO;
              res_o.last        = 1'b1;
            end else begin
              four_d   = (hdr_bpp == tgad_pkg::BPP_32);
              remain_d = area;
              bip_d    = 2'd0;
              phase_d  = raw_c ? tgad_pkg::PH_PIX : tgad_pkg::PH_HDR;
              res_o.result_kind    = tgad_pkg::KIND_INFO;
              res_o.image_width    = hdr_w;
              res_o.image_height   = hdr_h;
              res_o.bits_per_pixel = hdr_bpp;
            end
          end
        end

        tgad_pkg::PH_HDR: begin
          run_d   = data_byte_i[7];
          left_d  = data_byte_i[7] ? data_byte_i - tgad_pkg::RUN_BIAS : data_byte_i + 8'd1;
          bip_d   = 2'd0;
          phase_d = tgad_pkg::PH_PIX;
        end

        tgad_pkg::PH_PIX: begin
          if (bip_c < bip_need) begin
            case (bip_c)
              2'd0:    pix_d[7:0]   = data_byte_i;
              2'd1:    pix_d[15:8]  = data_byte_i;
              2'd2:    pix_d[23:16] = data_byte_i;
              default: pix_d = pix_q;
            endcase
            bip_d = bip_c + 2'd1;
          end else begin
            bip_d = 2'd0;
            res_valid_o = 1'b1;
            res_o.result_kind = tgad_pkg::KIND_PIXEL;
            res_o.red   = pix_r;
            res_o.green = pix_g;
            res_o.blue  = pix_b;
            res_o.alpha = pix_a;
            if (raw_c) begin
              if (remain_c == 32'd0) begin
                phase_d = tgad_pkg::PH_DONE;
                res_o = '0;
                res_o.result_kind = tgad_pkg::KIND_ERROR;
                res_o.error_code  = tgad_pkg::ERR_PIXELS;
                res_o.last        = 1'b1;
              end else begin
                remain_d = remain_dec;
                res_o.run_length = 8'd1;
                res_o.last = (remain_dec == 32'd0);
                if (remain_dec == 32'd0) phase_d = tgad_pkg::PH_DONE;
              end
            end else if (run_c) begin
              if (run_too_long) begin
                phase_d = tgad_pkg::PH_DONE;
                res_o = '0;
                res_o.result_kind = tgad_pkg::KIND_ERROR;
                res_o.error_code  = tgad_pkg::ERR_PIXELS;
                res_o.last        = 1'b1;
              end else begin
                remain_d = remain_sub;
                left_d   = 8'd0;
                res_o.run_length = left_c;
                res_o.last = (remain_sub == 32'd0);
                phase_d = (remain_sub == 32'd0) ? tgad_pkg::PH_DONE : tgad_pkg::PH_HDR;
              end
            end else begin
              if ((remain_c == 32'd0) || (left_c == 8'd0)) begin
                phase_d = tgad_pkg::PH_DONE;
                res_o = '0;
                res_o.result_kind = tgad_pkg::KIND_ERROR;
                res_o.error_code  = tgad_pkg::ERR_PIXELS;
                res_o.last        = 1'b1;
              end else begin
                remain_d = remain_dec;
                left_d   = left_dec;
                res_o.run_length = 8'd1;
                res_o.last = (remain_dec == 32'd0) && (left_dec == 8'd0);
                if ((remain_dec == 32'd0) && (left_dec == 8'd0)) begin
                  phase_d = tgad_pkg::PH_DONE;
                end else if (left_dec == 8'd0) begin
                  phase_d = tgad_pkg::PH_HDR;
                end
              end
            end
          end
        end

        // finished or failed image: bytes dropped until the next start mark
        default: begin
          phase_d = phase_c;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= tgad_pkg::PH_SIG;
      pos_q    <= 4'd0;
      raw_q    <= 1'b1;
      rle_q    <= 1'b1;
      four_q   <= 1'b0;
      remain_q <= 32'd0;
      run_q    <= 1'b0;
      left_q   <= 8'd0;
      bip_q    <= 2'd0;
    end else begin
      phase_q  <= phase_d;
      pos_q    <= pos_d;
      raw_q    <= raw_d;
      rle_q    <= rle_d;
      four_q   <= four_d;
      remain_q <= remain_d;
      run_q    <= run_d;
      left_q   <= left_d;
      bip_q    <= bip_d;
    end
  end

  always_ff @(posedge clk_i) begin
    hdr_q <= hdr_d;
    pix_q <= pix_d;
  end

endmodule

// ===== hw/rtl/tga_stream_decoder.sv =====
// Top level of the TGA stream decoder: input word register, parser and
// result register. Uses tgad_pkg, tgad_if.sv and tgad_parser.
//
// Usage:
//   in_i carries the file one byte per word, from offset zero. start_of_file
//   set on a word restarts the parser and takes that byte as offset zero.
//   out_o carries one word per result: image info after the 18-byte header,
//   then pixels (RGBA order, run_length copies each), or one error word.
//   last marks the word that completes the image or reports an error; later
//   bytes are dropped until the next start_of_file.
// Path: a byte is held in the input register from the accepting edge; its result
//   word goes into the result register at the edge where the parser steps on it.
// Throughput: one byte per cycle while out_o is not stalled; each byte goes
//   through the parser in one step, and a run packet yields one word with run_length.
// Reset: the parser waits for a signature at offset zero, both registers
//   are empty.
// Stall: while out_o.ready is low the result register holds a valid word; one
//   more byte is taken if the input register is empty, then in_i.ready drops.
module tga_stream_decoder (
  input  logic       clk_i,
  input  logic       rst_ni,
  tgad_in_if.sink    in_i,
  tgad_out_if.source out_o
);

  logic              in_valid_q;
  logic [7:0]        in_byte_q;
  logic              in_sof_q;
  logic              step;
  logic              res_valid;
  tgad_pkg::result_t res;
  logic              out_valid_q, out_valid_d;
  tgad_pkg::result_t out_q;

  assign step       = in_valid_q && (!out_valid_q || out_o.ready);
  assign in_i.ready = !in_valid_q || step;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      in_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.ready && in_i.valid) begin
      in_byte_q <= in_i.data_byte;
      in_sof_q  <= in_i.start_of_file;
    end
  end

  tgad_parser u_parser (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .step_i          (step),
    .data_byte_i     (in_byte_q),
    .start_of_file_i (in_sof_q),
    .res_valid_o     (res_valid),
    .res_o           (res)
  );

  always_comb begin
    out_valid_d = out_valid_q;
    if (step) begin
      out_valid_d = res_valid;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step && res_valid) begin
      out_q <= res;
    end
  end

  assign out_o.valid          = out_valid_q;
  assign out_o.result_kind    = out_q.result_kind;
  assign out_o.red            = out_q.red;
  assign out_o.green          = out_q.green;
  assign out_o.blue           = out_q.blue;
  assign out_o.alpha          = out_q.alpha;
  assign out_o.run_length     = out_q.run_length;
  assign out_o.image_width    = out_q.image_width;
  assign out_o.image_height   = out_q.image_height;
  assign out_o.bits_per_pixel = out_q.bits_per_pixel;
  assign out_o.error_code     = out_q.error_code;
  assign out_o.last           = out_q.last;

endmodule
